// ----- design/krpc_pkg.sv -----
package krpc_pkg;

  localparam int MAX_STRINGS_DEFAULT = 64;
  localparam int KEY_BITS_DEFAULT    = 40;
  localparam int COUNT_BITS_DEFAULT  = 16;

  localparam logic [6:0] NUM_STRINGS_RESET = 7'd64;

  localparam logic [1:0] REQ_PUSH   = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [39:0] feature_key;
    logic [5:0]  string_id;
    logic        last_feature;
    logic [5:0]  read_row;
    logic [5:0]  read_col;
  } in_word_t;

  typedef struct packed {
    logic [31:0] pair_count;
    logic [5:0]  entry_row;
    logic [5:0]  entry_col;
  } out_word_t;

endpackage

// ----- design/krpc_matrix.sv -----
module krpc_matrix #(
  parameter int DEPTH = 2080,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          clear,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  output logic          busy,
  output logic [AW-1:0] sweep_addr
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b1;
      sweep_addr <= '0;
    end else if (busy) begin
      if (sweep_addr == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
      sweep_addr <= sweep_addr + 1'b1;
    end else if (clear) begin
      busy       <= 1'b1;
      sweep_addr <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[sweep_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/kmer_run_pair_count_accumulate.sv -----
// Accumulates per-string feature counts over runs of equal keys and, when a run
// closes, adds count_a*count_b into a lower-triangular pair matrix for every pair
// of strings seen in the run. All work goes through one sequencer with one read
// and one write port on each memory, so the block takes one word at a time and
// holds in_stall high while busy. A read can also wait on out_stall. Closing a
// run is paced by the matrix, since each pair update reads and then writes its
// entry. A clear request, and the pass after reset, sweep the matrix one entry a
// cycle over all MAX_STRINGS*(MAX_STRINGS+1)/2 entries (2080 by default), with no
// word accepted meanwhile.
module kmer_run_pair_count_accumulate #(
  parameter int MAX_STRINGS = krpc_pkg::MAX_STRINGS_DEFAULT,
  parameter int KEY_BITS    = krpc_pkg::KEY_BITS_DEFAULT,
  parameter int COUNT_BITS  = krpc_pkg::COUNT_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  krpc_pkg::in_word_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output krpc_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data
);
  import krpc_pkg::*;

  localparam int IW = (MAX_STRINGS > 1) ? $clog2(MAX_STRINGS) : 1;
  localparam int NW = $clog2(MAX_STRINGS + 1);
  localparam int PD = MAX_STRINGS * (MAX_STRINGS + 1) / 2;
  localparam int AW = $clog2(PD);

  localparam logic [4:0] S_INIT  = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_CLEAR = 5'd2;
  localparam logic [4:0] S_RIDX  = 5'd3;
  localparam logic [4:0] S_RADR  = 5'd4;
  localparam logic [4:0] S_RMEM  = 5'd5;
  localparam logic [4:0] S_ROUT  = 5'd6;
  localparam logic [4:0] S_CRD   = 5'd7;
  localparam logic [4:0] S_CWR   = 5'd8;
  localparam logic [4:0] S_XRD   = 5'd9;
  localparam logic [4:0] S_XCNT  = 5'd10;
  localparam logic [4:0] S_XLAT  = 5'd11;
  localparam logic [4:0] S_YRD   = 5'd12;
  localparam logic [4:0] S_YCNT  = 5'd13;
  localparam logic [4:0] S_YMUL  = 5'd14;
  localparam logic [4:0] S_YIDX  = 5'd15;
  localparam logic [4:0] S_YMRD  = 5'd16;
  localparam logic [4:0] S_YMWR  = 5'd17;
  localparam logic [4:0] S_ZRD   = 5'd18;
  localparam logic [4:0] S_ZWR   = 5'd19;

  logic [4:0]            state;
  logic [6:0]            num_strings;
  logic [NW-1:0]         n_eff;
  logic [KEY_BITS-1:0]   key_q;
  logic [KEY_BITS-1:0]   key_in;
  logic [5:0]            sid_q;
  logic                  last_q;
  logic [5:0]            row_q;
  logic [5:0]            col_q;
  logic [5:0]            rh;
  logic [5:0]            rl;
  logic                  rd_ok;
  logic [KEY_BITS-1:0]   run_key;
  logic                  run_open;
  logic                  then_count;
  logic [NW-1:0]         total;
  logic [NW-1:0]         xi;
  logic [NW-1:0]         yi;
  logic [NW-1:0]         zi;
  logic [IW-1:0]         seen_mem [MAX_STRINGS];
  logic [IW-1:0]         seen_q;
  logic                  seen_rd;
  logic [IW-1:0]         seen_addr;
  logic [COUNT_BITS-1:0] cnt_mem [MAX_STRINGS];
  logic [COUNT_BITS-1:0] cnt_q;
  logic                  cnt_rd;
  logic [IW-1:0]         cnt_raddr;
  logic                  cnt_we;
  logic [IW-1:0]         cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [COUNT_BITS-1:0] ca;
  logic [IW-1:0]         sa;
  logic [IW-1:0]         sb;
  logic [IW-1:0]         ph;
  logic [IW-1:0]         pl;
  logic [31:0]           prod;
  logic [AW-1:0]         idx;
  logic                  mat_clear;
  logic                  mat_rd;
  logic [AW-1:0]         mat_raddr;
  logic [31:0]           mat_q;
  logic                  mat_we;
  logic                  sweep_busy;
  logic [AW-1:0]         sweep_addr;
  logic [2*COUNT_BITS-1:0] mul;
  logic [31:0]           tri_pair;
  logic [31:0]           tri_read;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign key_in    = KEY_BITS'(in_data.feature_key);

  always_comb begin
    if (num_strings == 7'd0) begin
      n_eff = NW'(1);
    end else if (32'(num_strings) > MAX_STRINGS) begin
      n_eff = NW'(MAX_STRINGS);
    end else begin
      n_eff = NW'(num_strings);
    end
  end

  assign mul      = ca * cnt_q;
  assign tri_pair = ((32'(ph) * (32'(ph) + 32'd1)) >> 1) + 32'(pl);
  assign tri_read = ((32'(rh) * (32'(rh) + 32'd1)) >> 1) + 32'(rl);

  always_comb begin
    seen_rd   = 1'b0;
    seen_addr = IW'(xi);
    cnt_rd    = 1'b0;
    cnt_raddr = IW'(sid_q);
    cnt_we    = 1'b0;
    cnt_waddr = IW'(sid_q);
    cnt_wdata = '0;
    mat_rd    = 1'b0;
    mat_raddr = idx;
    mat_we    = 1'b0;
    mat_clear = 1'b0;
    case (state)
      S_INIT: begin
        if (sweep_busy && (32'(sweep_addr) < MAX_STRINGS)) begin
          cnt_we    = 1'b1;
          cnt_waddr = IW'(sweep_addr);
        end
      end
      S_IDLE: begin
        mat_clear = in_valid && (in_data.req_type == REQ_CLEAR);
      end
      S_RMEM: begin
        mat_rd = rd_ok;
      end
      S_CRD: begin
        cnt_rd = (32'(sid_q) < 32'(n_eff));
      end
      S_CWR: begin
        cnt_we    = 1'b1;
        cnt_wdata = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
      end
      S_XRD: begin
        seen_rd = 1'b1;
      end
      S_XCNT: begin
        cnt_rd    = 1'b1;
        cnt_raddr = seen_q;
      end
      S_YRD: begin
        seen_rd   = 1'b1;
        seen_addr = IW'(yi);
      end
      S_YCNT: begin
        cnt_rd    = 1'b1;
        cnt_raddr = seen_q;
      end
      S_YMRD: begin
        mat_rd = 1'b1;
      end
      S_YMWR: begin
        mat_we = 1'b1;
      end
      S_ZRD: begin
        seen_rd   = 1'b1;
        seen_addr = IW'(zi);
      end
      S_ZWR: begin
        cnt_we    = 1'b1;
        cnt_waddr = seen_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (seen_rd) begin
      seen_q <= seen_mem[seen_addr];
    end
    if (state == S_CWR && cnt_q == '0 && 32'(total) < MAX_STRINGS) begin
      seen_mem[IW'(total)] <= IW'(sid_q);
    end
    if (cnt_rd) begin
      cnt_q <= cnt_mem[cnt_raddr];
    end
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      num_strings <= NUM_STRINGS_RESET;
      run_open    <= 1'b0;
      run_key     <= '0;
      total       <= '0;
      out_valid   <= 1'b0;
      then_count  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        num_strings <= cfg_data;
      end
      if (out_valid && !out_stall && state != S_ROUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT, S_CLEAR: begin
          if (!sweep_busy) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            key_q  <= key_in;
            sid_q  <= in_data.string_id;
            last_q <= in_data.last_feature;
            row_q  <= in_data.read_row;
            col_q  <= in_data.read_col;
            case (in_data.req_type)
              REQ_PUSH: begin
                if (run_open && key_in != run_key) begin
                  then_count <= 1'b1;
                  xi         <= '0;
                  state      <= S_XRD;
                end else begin
                  state <= S_CRD;
                end
              end
              REQ_READ:  state <= S_RIDX;
              REQ_CLEAR: state <= S_CLEAR;
              default:   state <= S_IDLE;
            endcase
          end
        end
        S_RIDX: begin
          rh    <= (row_q > col_q) ? row_q : col_q;
          rl    <= (row_q > col_q) ? col_q : row_q;
          rd_ok <= (32'(row_q) < 32'(n_eff)) && (32'(col_q) < 32'(n_eff));
          state <= S_RADR;
        end
        S_RADR: begin
          idx   <= AW'(tri_read);
          state <= S_RMEM;
        end
        S_RMEM: begin
          state <= S_ROUT;
        end
        S_ROUT: begin
          if (!out_valid || !out_stall) begin
            out_data.pair_count <= rd_ok ? mat_q : 32'd0;
            out_data.entry_row  <= rh;
            out_data.entry_col  <= rl;
            out_valid           <= 1'b1;
            state               <= S_IDLE;
          end
        end
        S_CRD: begin
          run_open <= 1'b1;
          run_key  <= key_q;
          if (32'(sid_q) < 32'(n_eff)) begin
            state <= S_CWR;
          end else if (last_q) begin
            then_count <= 1'b0;
            xi         <= '0;
            state      <= S_XRD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_CWR: begin
          if (cnt_q == '0 && 32'(total) < MAX_STRINGS) begin
            total <= total + 1'b1;
          end
          if (last_q) begin
            then_count <= 1'b0;
            xi         <= '0;
            state      <= S_XRD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_XRD: begin
          if (xi < total) begin
            state <= S_XCNT;
          end else begin
            zi    <= '0;
            state <= S_ZRD;
          end
        end
        S_XCNT: begin
          sa    <= seen_q;
          state <= S_XLAT;
        end
        S_XLAT: begin
          ca    <= cnt_q;
          yi    <= xi;
          state <= S_YRD;
        end
        S_YRD: begin
          state <= S_YCNT;
        end
        S_YCNT: begin
          sb    <= seen_q;
          state <= S_YMUL;
        end
        S_YMUL: begin
          prod  <= 32'(mul);
          ph    <= (sa > sb) ? sa : sb;
          pl    <= (sa > sb) ? sb : sa;
          state <= S_YIDX;
        end
        S_YIDX: begin
          idx   <= AW'(tri_pair);
          state <= S_YMRD;
        end
        S_YMRD: begin
          state <= S_YMWR;
        end
        S_YMWR: begin
          if (yi + 1'b1 < total) begin
            yi    <= yi + 1'b1;
            state <= S_YRD;
          end else begin
            xi    <= xi + 1'b1;
            state <= S_XRD;
          end
        end
        S_ZRD: begin
          if (zi < total) begin
            state <= S_ZWR;
          end else begin
            total    <= '0;
            run_open <= 1'b0;
            state    <= then_count ? S_CRD : S_IDLE;
          end
        end
        S_ZWR: begin
          zi    <= zi + 1'b1;
          state <= S_ZRD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  krpc_matrix #(
    .DEPTH (PD),
    .AW    (AW)
  ) u_matrix (
    .clk        (clk),
    .rst        (rst),
    .clear      (mat_clear),
    .rd_en      (mat_rd),
    .rd_addr    (mat_raddr),
    .rd_data    (mat_q),
    .wr_en      (mat_we),
    .wr_addr    (idx),
    .wr_data    (mat_q + prod),
    .busy       (sweep_busy),
    .sweep_addr (sweep_addr)
  );

  a_sweep_stalls: assert property (@(posedge clk) disable iff (rst)
    sweep_busy |-> in_stall)
    else $error("word accepted during matrix sweep");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    32'(total) <= MAX_STRINGS)
    else $error("seen count past string limit");

  a_out_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_ROUT)
    else $error("result raised outside read");

endmodule
